>>> src/jmi_pkg.sv
// Shared widths, constants and saturation helper for the joint motion integrator.
package jmi_pkg;

  localparam int CMD_W   = 2;
  localparam int ACC_W   = 24;
  localparam int ANG_W   = 32;
  localparam int MS_W    = 16;
  localparam int SPD_W   = 32;
  localparam int PROD_W  = 48;
  localparam int DIV_W   = 48;
  localparam int REM_W   = 10;
  localparam int Q_W     = 38;
  localparam int CHG_W   = 40;
  localparam int WIDE_W  = 41;
  localparam int ACC_SHIFT = 8;

  localparam int DIG_W      = 16;
  localparam int DIG_CNT_W  = 2;
  localparam int T_W        = REM_W + DIG_W;
  localparam int RCP_W      = 27;
  localparam int RCP_SHIFT  = 36;
  localparam int RCP_PROD_W = T_W + RCP_W;

  localparam logic [REM_W:0]        DIVISOR    = 11'd1000;
  localparam logic [DIV_W-1:0]      ROUND_HALF = 48'd500;
  localparam logic [RCP_W-1:0]      RECIP      = 27'd68719477;
  localparam logic [DIG_CNT_W-1:0]  DIG_LAST   = DIG_CNT_W'(DIV_W / DIG_W - 1);

  localparam logic [CMD_W-1:0] CMD_MOVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BRAKE = 2'd1;

  localparam logic signed [WIDE_W-1:0] SAT_MAX = 41'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -41'sd2147483648;

  function automatic logic signed [SPD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [SPD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/joint_motion_integrator_core.sv
// Top level of the joint motion integrator: sequencer, speed state and result register.
//
//  channel | dir | handshake              | word
//  in_     | in  | in_tvalid / in_tready  | tuser: command; tdata: accel, angle, elapsed_ms
//  out_    | out | out_tvalid / out_tready| tdata: new_angle
//
//  A move or brake word holds in_tready low for two passes of multiply, divider load
//  and divide by 1000 in three 16-bit digits, with clamp and both speed updates between
//  them, then the step to the output register.
//  With zero acceleration the first pass is skipped. An idle word is accepted without
//  leaving the idle state. Reset clears both speeds and the sequencer; the last step stalls
//  while an earlier result still waits in the output register.
module joint_motion_integrator_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [71:0] in_tdata,   // [23:0] accel_value, [55:24] present_angle, [71:56] elapsed_ms
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [31:0] new_angle
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DWAIT  = 3'd3;
  localparam logic [2:0] ST_CLAMP  = 3'd4;
  localparam logic [2:0] ST_FSUPD  = 3'd5;
  localparam logic [2:0] ST_AVUPD  = 3'd6;
  localparam logic [2:0] ST_FIN    = 3'd7;

  logic [2:0]                               state_r;
  logic                                     ph_r;
  logic                                     brake_r;
  logic                                     a_neg_r;
  logic [jmi_pkg::ACC_W-1:0]                a_mag_r;
  logic signed [jmi_pkg::ANG_W-1:0]         angle_r;
  logic [jmi_pkg::MS_W-1:0]                 ms_r;
  logic signed [jmi_pkg::SPD_W-1:0]         fs_r;
  logic signed [jmi_pkg::SPD_W-1:0]         avg_r;
  logic [jmi_pkg::Q_W-1:0]                  cm_r;
  logic signed [jmi_pkg::CHG_W-1:0]         chg_r;
  logic signed [jmi_pkg::CHG_W-1:0]         half_r;
  logic signed [jmi_pkg::ANG_W-1:0]         res_r;
  logic                                     out_valid_r;
  logic [jmi_pkg::ANG_W-1:0]                out_data_r;

  logic [jmi_pkg::CMD_W-1:0]                in_cmd;
  logic signed [jmi_pkg::ACC_W-1:0]         in_accel;
  logic [jmi_pkg::ACC_W-1:0]                in_mag;
  logic                                     in_acc_neg;

  logic [jmi_pkg::SPD_W-1:0]                mul_a;
  logic [jmi_pkg::PROD_W-1:0]               prod_r;
  logic                                     div_start;
  logic [jmi_pkg::DIV_W-1:0]                div_dvd;
  logic                                     div_done;
  logic [jmi_pkg::Q_W-1:0]                  div_q;

  logic [jmi_pkg::SPD_W-1:0]                avg_mag;
  logic [jmi_pkg::SPD_W:0]                  fs_abs;
  logic signed [jmi_pkg::CHG_W-1:0]         q_signed;
  logic signed [jmi_pkg::WIDE_W-1:0]        fs_sum;
  logic signed [jmi_pkg::WIDE_W-1:0]        avg_diff;
  logic signed [jmi_pkg::WIDE_W-1:0]        ang_sum;

  assign in_cmd     = in_tuser;
  assign in_accel   = in_tdata[23:0];
  assign in_mag     = in_accel[jmi_pkg::ACC_W-1] ? (~in_accel + 1'b1) : in_accel;
  assign in_acc_neg = (in_cmd == jmi_pkg::CMD_MOVE) ? in_accel[jmi_pkg::ACC_W-1]
                                                    : (!avg_r[jmi_pkg::SPD_W-1] && avg_r != '0);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign avg_mag  = avg_r[jmi_pkg::SPD_W-1] ? (~avg_r + 1'b1) : avg_r;
  assign fs_abs   = fs_r[jmi_pkg::SPD_W-1] ? (~{fs_r[jmi_pkg::SPD_W-1], fs_r} + 1'b1)
                                           : {1'b0, fs_r};
  assign mul_a    = ph_r ? avg_mag : jmi_pkg::SPD_W'(a_mag_r);
  assign div_start = (state_r == ST_DSTART);
  assign div_dvd  = ph_r ? (prod_r + jmi_pkg::ROUND_HALF)
                         : ({prod_r[jmi_pkg::PROD_W-jmi_pkg::ACC_SHIFT-1:0],
                             {jmi_pkg::ACC_SHIFT{1'b0}}} + jmi_pkg::ROUND_HALF);

  assign q_signed = ((ph_r ? avg_r[jmi_pkg::SPD_W-1] : a_neg_r))
                    ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
  assign fs_sum   = jmi_pkg::WIDE_W'(fs_r) + jmi_pkg::WIDE_W'(chg_r);
  assign avg_diff = jmi_pkg::WIDE_W'(fs_r) - jmi_pkg::WIDE_W'(half_r);
  assign ang_sum  = jmi_pkg::WIDE_W'(angle_r) + jmi_pkg::WIDE_W'(q_signed);

  jmi_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (ms_r),
    .prod_r (prod_r)
  );

  jmi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .done_r   (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ph_r        <= 1'b0;
      fs_r        <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            if (in_cmd != jmi_pkg::CMD_MOVE && in_cmd != jmi_pkg::CMD_BRAKE) begin
              fs_r <= '0;
            end else begin
              state_r <= ST_MUL;
              ph_r    <= (in_accel == '0);
            end
          end
        end
        ST_MUL:    state_r <= ST_DSTART;
        ST_DSTART: state_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            state_r <= ph_r ? ST_FIN : ST_CLAMP;
          end
        end
        ST_CLAMP:  state_r <= ST_FSUPD;
        ST_FSUPD: begin
          fs_r    <= jmi_pkg::sat32(fs_sum);
          state_r <= ST_AVUPD;
        end
        ST_AVUPD: begin
          avg_r   <= jmi_pkg::sat32(avg_diff);
          ph_r    <= 1'b1;
          state_r <= ST_MUL;
        end
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      brake_r <= (in_cmd == jmi_pkg::CMD_BRAKE);
      a_neg_r <= in_acc_neg;
      a_mag_r <= in_mag;
      angle_r <= in_tdata[55:24];
      ms_r    <= in_tdata[71:56];
    end
    if (state_r == ST_DWAIT && div_done) begin
      if (ph_r) begin
        res_r <= jmi_pkg::sat32(ang_sum);
      end else begin
        cm_r  <= div_q;
        chg_r <= q_signed;
      end
    end
    if (state_r == ST_CLAMP && brake_r && cm_r > jmi_pkg::Q_W'(fs_abs)) begin
      chg_r <= -jmi_pkg::CHG_W'(fs_r);
    end
    if (state_r == ST_FSUPD) begin
      half_r <= (chg_r + $signed(jmi_pkg::CHG_W'(chg_r[jmi_pkg::CHG_W-1]))) >>> 1;
    end
    if (state_r == ST_FIN && (!out_valid_r || out_tready)) begin
      out_data_r <= res_r;
    end
  end

endmodule

>>> src/jmi_mul.sv
// Registered unsigned 32 x 16 multiplier shared by both integration phases.
module jmi_mul (
  input  logic                        clk,
  input  logic [jmi_pkg::SPD_W-1:0]   op_a,
  input  logic [jmi_pkg::MS_W-1:0]    op_b,
  output logic [jmi_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= jmi_pkg::PROD_W'(op_a) * jmi_pkg::PROD_W'(op_b);
  end

endmodule

>>> src/jmi_div.sv
// Divider by the constant 1000: three 16-bit digits, reciprocal multiply then remainder fix-up.
module jmi_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [jmi_pkg::DIV_W-1:0]  dividend,
  output logic                       done_r,
  output logic [jmi_pkg::Q_W-1:0]    quotient
);

  logic                            busy_r;
  logic                            fix_r;
  logic [jmi_pkg::DIG_CNT_W-1:0]   digit_r;
  logic [jmi_pkg::DIV_W-1:0]       dvd_r;
  logic [jmi_pkg::REM_W-1:0]       rem_r;
  logic [jmi_pkg::Q_W-1:0]         quo_r;
  logic [jmi_pkg::RCP_PROD_W-1:0]  rcp_r;
  logic [jmi_pkg::T_W-1:0]         part;
  logic [jmi_pkg::DIG_W-1:0]       q_dig;
  logic [jmi_pkg::T_W-1:0]         back;
  logic [jmi_pkg::T_W-1:0]         rem_full;
  logic                            last;

  assign part     = {rem_r, dvd_r[jmi_pkg::DIV_W-1 -: jmi_pkg::DIG_W]};
  assign q_dig    = rcp_r[jmi_pkg::RCP_SHIFT +: jmi_pkg::DIG_W];
  assign back     = jmi_pkg::T_W'(q_dig) * jmi_pkg::T_W'(jmi_pkg::DIVISOR);
  assign rem_full = part - back;
  assign last     = busy_r && fix_r && (digit_r == jmi_pkg::DIG_LAST);
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      fix_r   <= 1'b0;
      digit_r <= '0;
    end else begin
      done_r <= last;
      if (start) begin
        busy_r  <= 1'b1;
        fix_r   <= 1'b0;
        digit_r <= '0;
      end else if (busy_r) begin
        fix_r <= !fix_r;
        if (fix_r) begin
          digit_r <= digit_r + 1'b1;
        end
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rcp_r <= jmi_pkg::RCP_PROD_W'(part) * jmi_pkg::RCP_PROD_W'(jmi_pkg::RECIP);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
    end else if (busy_r && fix_r) begin
      dvd_r <= {dvd_r[jmi_pkg::DIV_W-jmi_pkg::DIG_W-1:0], {jmi_pkg::DIG_W{1'b0}}};
      rem_r <= rem_full[jmi_pkg::REM_W-1:0];
      quo_r <= {quo_r[jmi_pkg::Q_W-jmi_pkg::DIG_W-1:0], q_dig};
    end
  end

endmodule
